>>> design/mcdel_pkg.sv
package mcdel_pkg;

    localparam int LANES            = 4;
    localparam int CARD_CHANNELS_DEF = 3;
    localparam int TIME_W           = 32;
    localparam int MS_W             = 16;
    localparam int CFG_IDX_W        = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_DEBOUNCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_DEAD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CARD_DEBOUNCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CARD_DEAD     = 3'd4;

    localparam logic [LANES-1:0] ACTIVE_LEVELS_RST = 4'd0;
    localparam logic [MS_W-1:0]  DEBOUNCE_RST      = 16'd5;
    localparam logic [MS_W-1:0]  DEAD_RST          = 16'd50;

    typedef struct packed {
        logic              init;
        logic              raw;
        logic [TIME_W-1:0] now;
        logic [MS_W-1:0]   debounce;
        logic [MS_W-1:0]   dead;
        logic              take_rise;
        logic              take_fall;
    } t_lane_in;

    typedef struct packed {
        logic stable;
        logic rise;
        logic fall;
    } t_lane_out;

    typedef struct packed {
        logic [LANES-1:0] stable_levels;
        logic [LANES-1:0] rise_pending;
        logic [LANES-1:0] fall_pending;
    } t_result;

endpackage

>>> design/multi_channel_debounce_edge_latch_unit.sv
// channel | handshake               | payload
// input   | i_in_valid / o_in_stall | i_req_type, i_pin_levels, i_now_time,
//         |                         | i_take_rise, i_take_fall
// output  | o_out_valid / i_out_stall | o_stable_levels, o_rise_pending,
//         |                         | o_fall_pending
// config  | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One beat per cycle unless o_in_stall is high; each result is registered.
// Every channel lane updates in the cycle of acceptance. Synchronous
// active-low reset clears all lane state and the valid flags of both output
// stages. A two-entry output buffer (output register plus skid) absorbs one
// stalled result; o_in_stall rises only while the skid stage holds a beat.
module multi_channel_debounce_edge_latch_unit #(
    parameter int CARD_CHANNELS = mcdel_pkg::CARD_CHANNELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_req_type,
    input  logic [mcdel_pkg::LANES-1:0]        i_pin_levels,
    input  logic [mcdel_pkg::TIME_W-1:0]       i_now_time,
    input  logic [mcdel_pkg::LANES-1:0]        i_take_rise,
    input  logic [mcdel_pkg::LANES-1:0]        i_take_fall,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [mcdel_pkg::LANES-1:0]        o_stable_levels,
    output logic [mcdel_pkg::LANES-1:0]        o_rise_pending,
    output logic [mcdel_pkg::LANES-1:0]        o_fall_pending,
    input  logic                               i_cfg_we,
    input  logic [mcdel_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mcdel_pkg::MS_W-1:0]         i_cfg_data
);

    localparam int NUM_CH = ((CARD_CHANNELS + 1) > mcdel_pkg::LANES) ?
                            mcdel_pkg::LANES : (CARD_CHANNELS + 1);

    logic [mcdel_pkg::LANES-1:0] r_active_levels;
    logic [mcdel_pkg::MS_W-1:0]  r_home_debounce;
    logic [mcdel_pkg::MS_W-1:0]  r_home_dead;
    logic [mcdel_pkg::MS_W-1:0]  r_card_debounce;
    logic [mcdel_pkg::MS_W-1:0]  r_card_dead;

    logic                        accept;
    logic                        full;
    logic [mcdel_pkg::LANES-1:0] raw;
    logic [mcdel_pkg::LANES-1:0] lane_used;
    mcdel_pkg::t_lane_out        lane_out [mcdel_pkg::LANES];
    mcdel_pkg::t_result          result;

    assign accept     = i_in_valid & ~full;
    assign o_in_stall = full;
    assign raw        = ~(i_pin_levels ^ r_active_levels);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_levels <= mcdel_pkg::ACTIVE_LEVELS_RST;
            r_home_debounce <= mcdel_pkg::DEBOUNCE_RST;
            r_home_dead     <= mcdel_pkg::DEAD_RST;
            r_card_debounce <= mcdel_pkg::DEBOUNCE_RST;
            r_card_dead     <= mcdel_pkg::DEAD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mcdel_pkg::REG_ACTIVE_LEVELS: begin
                    r_active_levels <= i_cfg_data[mcdel_pkg::LANES-1:0];
                end
                mcdel_pkg::REG_HOME_DEBOUNCE: r_home_debounce <= i_cfg_data;
                mcdel_pkg::REG_HOME_DEAD:     r_home_dead     <= i_cfg_data;
                mcdel_pkg::REG_CARD_DEBOUNCE: r_card_debounce <= i_cfg_data;
                mcdel_pkg::REG_CARD_DEAD:     r_card_dead     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < mcdel_pkg::LANES; g++) begin : g_lane
        if (g < NUM_CH) begin : g_on
            mcdel_pkg::t_lane_in lane_in;

            assign lane_in.init      = ~i_req_type;
            assign lane_in.raw       = raw[g];
            assign lane_in.now       = i_now_time;
            assign lane_in.debounce  = (g == 0) ? r_home_debounce : r_card_debounce;
            assign lane_in.dead      = (g == 0) ? r_home_dead : r_card_dead;
            assign lane_in.take_rise = i_take_rise[g];
            assign lane_in.take_fall = i_take_fall[g];
            assign lane_used[g]      = 1'b1;

            mcdel_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_accept (accept),
                .i_lane   (lane_in),
                .o_lane   (lane_out[g])
            );
        end else begin : g_off
            assign lane_used[g] = 1'b0;
            assign lane_out[g]  = '0;
        end
    end

    mcdel_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_lanes     (lane_out),
        .i_lane_used (lane_used),
        .i_out_stall (i_out_stall),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_stable_levels = result.stable_levels;
    assign o_rise_pending  = result.rise_pending;
    assign o_fall_pending  = result.fall_pending;

endmodule

>>> design/mcdel_lane.sv
module mcdel_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  mcdel_pkg::t_lane_in i_lane,
    output mcdel_pkg::t_lane_out o_lane
);

    logic                         r_stable, n_stable;
    logic                         r_last_raw, n_last_raw;
    logic [mcdel_pkg::TIME_W-1:0] r_change, n_change;
    logic [mcdel_pkg::TIME_W-1:0] r_event, n_event;
    logic                         r_rise, n_rise;
    logic                         r_fall, n_fall;

    logic [mcdel_pkg::TIME_W-1:0] chg_stamp;
    logic [mcdel_pkg::TIME_W-1:0] since_chg;
    logic [mcdel_pkg::TIME_W-1:0] since_evt;
    logic                         held;
    logic                         dead_ok;
    logic                         rep_rise;
    logic                         rep_fall;

    assign chg_stamp = (i_lane.raw != r_last_raw) ? i_lane.now : r_change;
    assign since_chg = i_lane.now - chg_stamp;
    assign since_evt = i_lane.now - r_event;
    assign held      = since_chg >= {{(mcdel_pkg::TIME_W-mcdel_pkg::MS_W){1'b0}}, i_lane.debounce};
    // a stamp of zero means no event so far
    assign dead_ok   = (r_event == '0) ||
                       (since_evt >= {{(mcdel_pkg::TIME_W-mcdel_pkg::MS_W){1'b0}}, i_lane.dead});

    always_comb begin
        n_stable   = r_stable;
        n_last_raw = i_lane.raw;
        n_change   = chg_stamp;
        n_event    = r_event;
        rep_rise   = r_rise;
        rep_fall   = r_fall;
        if (i_lane.init) begin
            n_stable = i_lane.raw;
            n_change = i_lane.now;
            n_event  = '0;
            rep_rise = 1'b0;
            rep_fall = 1'b0;
        end else if ((i_lane.raw != r_stable) && held) begin
            n_stable = i_lane.raw;
            if (dead_ok) begin
                n_event = i_lane.now;
                if (i_lane.raw) begin
                    rep_rise = 1'b1;
                end else begin
                    rep_fall = 1'b1;
                end
            end
        end
        n_rise = rep_rise & ~i_lane.take_rise;
        n_fall = rep_fall & ~i_lane.take_fall;
    end

    assign o_lane.stable = n_stable;
    assign o_lane.rise   = rep_rise;
    assign o_lane.fall   = rep_fall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable   <= 1'b0;
            r_last_raw <= 1'b0;
            r_change   <= '0;
            r_event    <= '0;
            r_rise     <= 1'b0;
            r_fall     <= 1'b0;
        end else if (i_accept) begin
            r_stable   <= n_stable;
            r_last_raw <= n_last_raw;
            r_change   <= n_change;
            r_event    <= n_event;
            r_rise     <= n_rise;
            r_fall     <= n_fall;
        end
    end

endmodule

>>> design/mcdel_merge.sv
module mcdel_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mcdel_pkg::t_lane_out i_lanes [mcdel_pkg::LANES],
    input  logic [mcdel_pkg::LANES-1:0] i_lane_used,
    input  logic               i_out_stall,
    output logic               o_full,
    output logic               o_out_valid,
    output mcdel_pkg::t_result o_result
);

    mcdel_pkg::t_result r_out, n_out;
    mcdel_pkg::t_result r_skid, n_skid;
    mcdel_pkg::t_result merged;
    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    logic               pop;

    // gather lane bits into fields; absent channels read as zero
    always_comb begin
        for (int l = 0; l < mcdel_pkg::LANES; l++) begin
            merged.stable_levels[l] = i_lanes[l].stable & i_lane_used[l];
            merged.rise_pending[l]  = i_lanes[l].rise   & i_lane_used[l];
            merged.fall_pending[l]  = i_lanes[l].fall   & i_lane_used[l];
        end
    end

    assign pop = r_out_valid & ~i_out_stall;

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                n_out       = merged;
                n_out_valid = 1'b1;
            end else begin
                // output stalled: park the beat in the skid stage
                n_skid       = merged;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

>>> design/mcdel_checker.sv
module mcdel_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            i_req_type,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [mcdel_pkg::LANES-1:0]     o_stable_levels,
    input logic [mcdel_pkg::LANES-1:0]     o_rise_pending,
    input logic [mcdel_pkg::LANES-1:0]     o_fall_pending
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid &&
            $stable(o_stable_levels) && $stable(o_rise_pending) &&
            $stable(o_fall_pending))
        else $error("stalled result beat changed");

    // with nothing on the output the skid stage must be empty
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output is empty");

    // an init beat into an idle output shows next cycle with all pending flags clear
    a_init_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_req_type && !o_out_valid |=>
            o_out_valid && (o_rise_pending == '0) && (o_fall_pending == '0))
        else $error("init beat did not produce a cleared result");

    // a taken beat into an idle output appears the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> o_out_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind multi_channel_debounce_edge_latch_unit mcdel_checker u_mcdel_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_req_type      (i_req_type),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_stable_levels (o_stable_levels),
    .o_rise_pending  (o_rise_pending),
    .o_fall_pending  (o_fall_pending)
);
